/* rtl/rgba8_pkg.sv */
// Package with the pixel transaction types, format codes and channel rounding functions.
`default_nettype none

package rgba8_pkg;

    typedef enum logic [2:0] {
        FMT_PASS = 3'd0,
        FMT_4444 = 3'd1,
        FMT_1555 = 3'd2,
        FMT_BGRA = 3'd3,
        FMT_RGB8 = 3'd4
    } fmt_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last_pixel;
    } pixel_in_t;

    typedef struct packed {
        logic [31:0] packed_pixel;
        logic [2:0]  byte_count;
        logic        last_out;
    } pixel_out_t;

    localparam logic [2:0] BYTES_2 = 3'd2;
    localparam logic [2:0] BYTES_3 = 3'd3;
    localparam logic [2:0] BYTES_4 = 3'd4;

    // Rounds an 8-bit channel to 4 bits: round(c*15/255) equals floor((c+8)/17).
    // The quotient comes from a multiply by 15/256 with one correction step.
    function automatic logic [3:0] to4(input logic [7:0] c);
        logic [8:0]  x;
        logic [12:0] prod;
        logic [4:0]  q;
        logic [9:0]  rem;
        x    = {1'b0, c} + 9'd8;
        prod = {4'd0, x} * 13'd15;
        q    = prod[12:8];
        rem  = {1'b0, x} - ({5'd0, q} * 10'd17);
        if (rem >= 10'd17)
        begin
            q = q + 5'd1;
        end
        return q[3:0];
    endfunction

    // Rounds an 8-bit channel to 5 bits: floor((62*c + 255) / 510).
    // The quotient comes from a multiply by 257/2^17 with one correction step.
    function automatic logic [4:0] to5(input logic [7:0] c);
        logic [13:0] x;
        logic [22:0] prod;
        logic [5:0]  q;
        logic [14:0] rem;
        x    = ({6'd0, c} * 14'd62) + 14'd255;
        prod = {9'd0, x} * 23'd257;
        q    = prod[22:17];
        rem  = {1'b0, x} - ({9'd0, q} * 15'd510);
        if (rem >= 15'd510)
        begin
            q = q + 6'd1;
        end
        return q[4:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/rgba8_pixel_format_converter.sv */
// Top level of the RGBA8 pixel format converter.
`default_nettype none

// The converter takes one RGBA8 pixel per transaction and returns one packed
// pixel per transaction, in the format selected by the format register
// (0 passthrough RGBA8, 1 B4G4R4A4, 2 A1R5G5B5, 3 B8G8R8A8, 4 R8G8B8; codes 5
// to 7 behave as passthrough). Reduced channels are rounded to nearest exactly.
// The block is a two-register pipeline: an input register and a result
// register with the rounding and packing logic between them. It accepts one
// pixel every clock cycle while the output side keeps taking results. An
// accepted pixel is rounded and packed from the input register into the
// result register, from which it is offered on the output. Both stages stall
// in place when the output is held off, so the block holds at most two pixels
// and no transaction is lost. The configuration register is always ready and
// should be written only while the pipeline holds no pixels; it takes effect
// for the next pixel accepted.
module rgba8_pixel_format_converter (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [2:0]            cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire rgba8_pkg::pixel_in_t  in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output rgba8_pkg::pixel_out_t      out_data
);
    import rgba8_pkg::*;

    fmt_t       fmt_reg;
    logic       s0_valid_reg;
    pixel_in_t  s0_data_reg;
    logic       out_valid_reg;
    pixel_out_t out_data_reg;
    pixel_out_t out_data_next;
    logic       adv_out;
    logic       adv_in;

    // The result register takes a new value when it is empty or being drained.
    assign adv_out   = !out_valid_reg || out_ready;
    // The input register can load when empty or when its pixel moves on.
    assign in_ready  = !s0_valid_reg || adv_out;
    assign adv_in    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_PASS;
        end
        else if (cfg_valid)
        begin
            fmt_reg <= fmt_t'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s0_valid_reg <= in_valid;
            end
            if (adv_out)
            begin
                out_valid_reg <= s0_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_in)
        begin
            s0_data_reg <= in_data;
        end
        if (adv_out && s0_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Rounding and packing of the pixel held in the input register.
    always_comb
    begin
        out_data_next.last_out = s0_data_reg.last_pixel;
        case (fmt_reg)
            FMT_4444:
            begin
                out_data_next.packed_pixel = {16'd0, to4(s0_data_reg.blue),
                    to4(s0_data_reg.green), to4(s0_data_reg.red), to4(s0_data_reg.alpha)};
                out_data_next.byte_count   = BYTES_2;
            end
            FMT_1555:
            begin
                out_data_next.packed_pixel = {16'd0, 1'b1, to5(s0_data_reg.red),
                    to5(s0_data_reg.green), to5(s0_data_reg.blue)};
                out_data_next.byte_count   = BYTES_2;
            end
            FMT_BGRA:
            begin
                out_data_next.packed_pixel = {s0_data_reg.alpha, s0_data_reg.red,
                    s0_data_reg.green, s0_data_reg.blue};
                out_data_next.byte_count   = BYTES_4;
            end
            FMT_RGB8:
            begin
                out_data_next.packed_pixel = {8'd0, s0_data_reg.blue,
                    s0_data_reg.green, s0_data_reg.red};
                out_data_next.byte_count   = BYTES_3;
            end
            default:
            begin
                // Passthrough, which also covers the unassigned format codes.
                out_data_next.packed_pixel = {s0_data_reg.alpha, s0_data_reg.blue,
                    s0_data_reg.green, s0_data_reg.red};
                out_data_next.byte_count   = BYTES_4;
            end
        endcase
    end

endmodule

`default_nettype wire
